[src/xor_pair_fec_packetizer_unit_macros.svh]
// assertion helpers for the xor pair fec packetizer
`ifndef XOR_PAIR_FEC_PACKETIZER_UNIT_MACROS_SVH
`define XOR_PAIR_FEC_PACKETIZER_UNIT_MACROS_SVH

// checked only outside reset
`define XPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define XPF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[src/xpf_pkg.sv]
package xpf_pkg;

  localparam int unsigned PAYLOAD_BYTES = 160;
  localparam int unsigned SEQ_BYTES     = 4;
  localparam int unsigned DGRAM_BYTES   = SEQ_BYTES + PAYLOAD_BYTES;
  localparam int unsigned PKT_BYTES     = SEQ_BYTES + 1 + PAYLOAD_BYTES;
  localparam int unsigned WORD_BYTES    = 8;
  localparam int unsigned WORD_W        = 8 * WORD_BYTES;
  localparam int unsigned PKT_WORDS     = (PKT_BYTES + WORD_BYTES - 1) / WORD_BYTES;
  localparam int unsigned LAST_BYTES    = (PKT_BYTES % WORD_BYTES == 0) ? WORD_BYTES
                                                                        : PKT_BYTES % WORD_BYTES;
  localparam int unsigned WORD_AW       = $clog2(PKT_WORDS);
  localparam int unsigned STORE_AW      = WORD_AW + 1;
  localparam int unsigned STORE_DEPTH   = 2 ** STORE_AW;
  localparam int unsigned CACHE_DEPTH   = 2 ** WORD_AW;
  localparam int unsigned IDX_W         = $clog2(DGRAM_BYTES + 1);
  localparam int unsigned CNT_W         = 4;
  localparam int unsigned JOBQ_DEPTH    = 2;
  localparam int unsigned JQ_AW         = $clog2(JOBQ_DEPTH);
  localparam int unsigned JQ_CW         = $clog2(JOBQ_DEPTH + 1);

  // keeps the top LAST_BYTES byte lanes of the final packet word
  localparam logic [WORD_W-1:0] LAST_MASK = ~({WORD_W{1'b1}} >> (8 * LAST_BYTES));

  typedef enum logic [0:0] {
    KIND_MEDIA = 1'b0,
    KIND_FEC   = 1'b1
  } kind_e;

  typedef struct packed {
    logic [8*SEQ_BYTES-1:0] seq;
    logic                   bank;
  } job_t;

  typedef struct packed {
    logic                en;
    logic [STORE_AW-1:0] addr;
    logic [WORD_W-1:0]   data;
  } st_wr_t;

  typedef struct packed {
    logic                en;
    logic [STORE_AW-1:0] addr;
  } st_rd_t;

endpackage

[src/xpf_ram.sv]
module xpf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/xpf_jobq.sv]
module xpf_jobq import xpf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output job_t head_o,
  output logic empty_o,
  output logic full_o
);

  job_t             ent_q [JOBQ_DEPTH];
  logic [JQ_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [JQ_CW-1:0] cnt_q, cnt_d;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + JQ_CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - JQ_CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + JQ_AW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + JQ_AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= job_i;
    end
  end

  assign head_o  = ent_q[rd_ptr_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == JQ_CW'(JOBQ_DEPTH));

endmodule

[src/xpf_front.sv]
module xpf_front import xpf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] in_byte_i,
  input  logic       datagram_end_i,
  output logic       push_o,
  output job_t       job_o,
  output st_wr_t     st_wr_o
);

  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [8*SEQ_BYTES-1:0] seq_q, seq_d;
  logic [WORD_W-1:0]      asm_q, asm_d;
  logic                   bank_q, bank_d;
  logic [IDX_W-1:0]       pos;
  logic [2:0]             lane;
  logic                   in_range, is_payload;

  // payload byte sits at its packet position: one past the datagram position
  assign pos        = idx_q + IDX_W'(1);
  assign lane       = pos[2:0];
  assign in_range   = (idx_q < IDX_W'(DGRAM_BYTES));
  assign is_payload = in_range && (idx_q >= IDX_W'(SEQ_BYTES));

  always_comb begin
    idx_d   = idx_q;
    seq_d   = seq_q;
    asm_d   = asm_q;
    bank_d  = bank_q;
    push_o  = 1'b0;
    st_wr_o = '0;
    if (accept_i) begin
      if (in_range) begin
        idx_d = idx_q + IDX_W'(1);
        if (!is_payload) begin
          seq_d = {seq_q[8*SEQ_BYTES-9:0], in_byte_i};
        end else begin
          asm_d[{~lane, 3'b000} +: 8] = in_byte_i;
          st_wr_o.en   = (lane == 3'd7) || (idx_q == IDX_W'(DGRAM_BYTES - 1));
          st_wr_o.addr = {bank_q, WORD_AW'(pos >> 3)};
          st_wr_o.data = asm_d;
        end
      end
      if (datagram_end_i) begin
        idx_d = '0;
        // full length datagram: hand the bank over to the back end
        if (idx_q >= IDX_W'(DGRAM_BYTES - 1)) begin
          push_o = 1'b1;
          bank_d = ~bank_q;
        end
      end
    end
  end

  assign job_o.seq  = seq_q;
  assign job_o.bank = bank_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      seq_q  <= '0;
      bank_q <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      seq_q  <= seq_d;
      bank_q <= bank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    asm_q <= asm_d;
  end

endmodule

[src/xpf_back.sv]
module xpf_back import xpf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  job_t              head_i,
  input  logic              empty_i,
  output logic              pop_o,
  output st_rd_t            st_rd_o,
  input  logic [WORD_W-1:0] st_rdata_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [WORD_W-1:0] out_word_o,
  output logic [CNT_W-1:0]  byte_count_o,
  output kind_e             packet_kind_o,
  output logic              packet_end_o,
  output logic              run_end_o
);

  // issue counters
  logic [WORD_AW-1:0] word_q, word_d;
  kind_e              pass_q, pass_d;

  // read stage
  logic               rd_vld_q;
  logic [WORD_AW-1:0] rd_word_q;
  kind_e              rd_kind_q;
  logic               rd_last_q, rd_run_q, rd_cwr_q, rd_cvld_q;

  // output register
  logic               out_vld_q;
  logic [WORD_W-1:0]  out_word_q;
  logic [CNT_W-1:0]   out_cnt_q;
  kind_e              out_kind_q;
  logic               out_last_q, out_run_q;

  logic [PKT_WORDS-1:0]   cache_vld_q;
  logic [WORD_W-1:0]      cache_rdata, par, body;
  logic [8*SEQ_BYTES-1:0] hdr_seq;
  logic                   out_adv, rd_free, issue, last_w, odd, cache_we;

  assign out_adv  = !out_vld_q || out_ready_i;
  assign rd_free  = !rd_vld_q || out_adv;
  assign issue    = !empty_i && rd_free;
  assign last_w   = (word_q == WORD_AW'(PKT_WORDS - 1));
  assign odd      = head_i.seq[0];
  assign cache_we = out_adv && rd_vld_q && rd_cwr_q;

  always_comb begin
    word_d = word_q;
    pass_d = pass_q;
    pop_o  = 1'b0;
    if (issue) begin
      if (last_w) begin
        word_d = '0;
        if (pass_q == KIND_MEDIA && odd) begin
          pass_d = KIND_FEC;
        end else begin
          pass_d = KIND_MEDIA;
          pop_o  = 1'b1;
        end
      end else begin
        word_d = word_q + WORD_AW'(1);
      end
    end
  end

  assign st_rd_o.en   = issue;
  assign st_rd_o.addr = {head_i.bank, word_q};

  xpf_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CACHE_DEPTH)
  ) u_cache (
    .clk_i   (clk_i),
    .we_i    (cache_we),
    .waddr_i (rd_word_q),
    .wdata_i (st_rdata_i),
    .re_i    (issue),
    .raddr_i (word_q),
    .rdata_o (cache_rdata)
  );

  // word assembly: header overlay on word 0, tail mask on the last word
  always_comb begin
    par     = rd_cvld_q ? cache_rdata : '0;
    body    = (rd_kind_q == KIND_FEC) ? (st_rdata_i ^ par) : st_rdata_i;
    hdr_seq = (rd_kind_q == KIND_FEC) ? (head_i.seq - 32'd1) : head_i.seq;
    if (rd_word_q == '0) begin
      body = {7'b0000000, rd_kind_q, hdr_seq, body[WORD_W-8*(SEQ_BYTES+1)-1:0]};
    end
    if (rd_last_q) begin
      body = body & LAST_MASK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q      <= '0;
      pass_q      <= KIND_MEDIA;
      rd_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
      cache_vld_q <= '0;
    end else begin
      word_q <= word_d;
      pass_q <= pass_d;
      if (issue) begin
        rd_vld_q <= 1'b1;
      end else if (out_adv) begin
        rd_vld_q <= 1'b0;
      end
      if (out_adv) begin
        out_vld_q <= rd_vld_q;
      end
      if (cache_we) begin
        cache_vld_q[rd_word_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_word_q <= word_q;
      rd_kind_q <= pass_q;
      rd_last_q <= last_w;
      rd_run_q  <= last_w && (pass_q == KIND_FEC || !odd);
      rd_cwr_q  <= (pass_q == KIND_MEDIA) && !odd;
      rd_cvld_q <= cache_vld_q[word_q];
    end
    if (out_adv && rd_vld_q) begin
      out_word_q <= body;
      out_cnt_q  <= rd_last_q ? CNT_W'(LAST_BYTES) : CNT_W'(WORD_BYTES);
      out_kind_q <= rd_kind_q;
      out_last_q <= rd_last_q;
      out_run_q  <= rd_run_q;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign out_word_o    = out_word_q;
  assign byte_count_o  = out_cnt_q;
  assign packet_kind_o = out_kind_q;
  assign packet_end_o  = out_last_q;
  assign run_end_o     = out_run_q;

endmodule

[src/xor_pair_fec_packetizer_unit.sv]
// xor pair fec packetizer: 2:1 xor parity fec over fixed size datagrams
// slave stream: one datagram byte per request in tdata[7:0], tlast on the
//   final byte; 4 sequence bytes (big-endian) then the payload, extra bytes
//   are dropped, a short datagram emits nothing and leaves the cache alone
// master stream: 8-byte words, first wire byte in tdata[63:56], byte count
//   in tdata[67:64], run end in tdata[68], packet kind in tuser, tlast on the
//   final word of each packet (that word holds LAST_BYTES bytes, 5 here)
// per full datagram: a media packet of 21 words, and for an odd sequence an
//   fec packet of 21 more words (cache xor payload, sequence minus one)
// first word: the final byte queues the job, which then passes the read stage
//   and the output register; then one word per cycle while the receiver takes them
// input rate: one byte per cycle; the store holds two datagram banks, so a
//   new datagram streams in while the previous one is sent, and tready drops
//   only while two finished datagrams wait in the job queue
// receiver stall: the output register and the read stage hold their words,
//   the back end stops issuing reads, the front keeps filling its bank
// reset: counters, job queue and cache valid bits clear at once; the parity
//   cache reads as zeros until an even datagram writes it
module xor_pair_fec_packetizer_unit import xpf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  logic        s_axis_tlast_i,   // datagram_end
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,   // [63:0] out_word, [67:64] byte_count,
                                        // [68] run_end, [71:69] zero
  output logic        m_axis_tuser_o,   // [0] packet_kind
  output logic        m_axis_tlast_o    // packet_end
);

  logic              accept;
  logic              push, pop, q_empty, q_full;
  job_t              push_job, head_job;
  st_wr_t            st_wr;
  st_rd_t            st_rd;
  logic [WORD_W-1:0] st_rdata;
  logic [WORD_W-1:0] out_word;
  logic [CNT_W-1:0]  byte_count;
  kind_e             packet_kind;
  logic              run_end;

  // both store banks busy once two jobs are queued
  assign s_axis_tready_o = !q_full;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // front: byte collection into the free bank
  xpf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .in_byte_i      (s_axis_tdata_i),
    .datagram_end_i (s_axis_tlast_i),
    .push_o         (push),
    .job_o          (push_job),
    .st_wr_o        (st_wr)
  );

  // datagram store: two banks of packet-aligned words
  xpf_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_wr.en),
    .waddr_i (st_wr.addr),
    .wdata_i (st_wr.data),
    .re_i    (st_rd.en),
    .raddr_i (st_rd.addr),
    .rdata_o (st_rdata)
  );

  // job queue: one entry per finished datagram, popped when its last read is issued
  xpf_jobq u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .head_o  (head_job),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // back: packet word generation and parity cache
  xpf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head_job),
    .empty_i       (q_empty),
    .pop_o         (pop),
    .st_rd_o       (st_rd),
    .st_rdata_i    (st_rdata),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_word_o    (out_word),
    .byte_count_o  (byte_count),
    .packet_kind_o (packet_kind),
    .packet_end_o  (m_axis_tlast_o),
    .run_end_o     (run_end)
  );

  assign m_axis_tdata_o = {3'b000, run_end, byte_count, out_word};
  assign m_axis_tuser_o = packet_kind;

endmodule

[src/xpf_checker.sv]
`include "xor_pair_fec_packetizer_unit_macros.svh"

module xpf_checker import xpf_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [71:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o
);

  // the output register clears asynchronously while reset is held
  `XPF_ASSERT_ALWAYS(a_no_valid_in_reset, !rst_ni |=> !m_axis_tvalid_o, "tvalid during reset")

  `XPF_ASSERT(a_valid_held, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o, "tvalid dropped")

  `XPF_ASSERT(a_full_word, m_axis_tvalid_o && !m_axis_tlast_o |-> m_axis_tdata_o[67:64] == CNT_W'(WORD_BYTES), "short inner word")

  `XPF_ASSERT(a_last_word, m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tdata_o[67:64] == CNT_W'(LAST_BYTES), "bad tail count")

  `XPF_ASSERT(a_run_end_on_last, m_axis_tvalid_o && m_axis_tdata_o[68] |-> m_axis_tlast_o, "run end off packet end")

endmodule

bind xor_pair_fec_packetizer_unit xpf_checker u_xpf_checker (.*);
